[rtl/ajrb_pkg.sv]
// ----------------------------------------------------------------------------
// ajrb_pkg
// Shared types and constants of the audio jitter ring buffer.
// ----------------------------------------------------------------------------
package ajrb_pkg;

    // ring store size, 16 .. 65536 entries
    localparam int RING_DEPTH = 65536;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int FILL_W     = $clog2(RING_DEPTH + 1);

    localparam int SAMPLE_W   = 16;
    localparam int OUT_W      = 32;
    localparam int CNT_W      = 32;
    localparam int LEVEL_W    = 17;

    localparam int THR_W      = 17;
    localparam int LEN_W      = 11;
    localparam int POS_W      = 10;
    localparam int CHUNK_MAX  = 1024;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_WARMUP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK  = CFG_IDX_W'(1);

    localparam logic [THR_W-1:0] WARMUP_RESET = THR_W'(4800);
    localparam logic [LEN_W-1:0] CHUNK_RESET  = LEN_W'(160);

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture the accepted item
        logic exec;   // apply the captured item
    } t_dp_cmd;

endpackage

[rtl/ajrb_ram.sv]
// ----------------------------------------------------------------------------
// ajrb_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ajrb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ajrb_ctrl.sv]
// ----------------------------------------------------------------------------
// ajrb_ctrl
// Sequencer: accept one command, execute it, strobe the result.
// ----------------------------------------------------------------------------
module ajrb_ctrl import ajrb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    output logic    o_done,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_done;
    logic   accept;

    assign accept = start && (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == ST_EXEC);
        end
    end

    assign busy       = (r_state != ST_IDLE);
    assign o_done     = r_done;
    assign o_cmd.load = accept;
    assign o_cmd.exec = (r_state == ST_EXEC);

    // execute only right after a transfer
    a_exec_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |-> $past(start && r_state == ST_IDLE))
        else $error("exec without accepted command");

    // one strobe per executed command
    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state == ST_EXEC))
        else $error("result strobe without execution");

endmodule

[rtl/ajrb_dp.sv]
// ----------------------------------------------------------------------------
// ajrb_dp
// Datapath: ring pointers, fill, chunk accounting, counters, result regs.
// ----------------------------------------------------------------------------
module ajrb_dp import ajrb_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    input  logic                   i_command,
    input  logic [SAMPLE_W-1:0]    i_sample,
    input  logic                   i_packet_start,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output logic [OUT_W-1:0]       o_left_sample,
    output logic [OUT_W-1:0]       o_right_sample,
    output logic                   o_from_buffer,
    output logic                   o_playing,
    output logic [LEVEL_W-1:0]     o_fill_level,
    output logic [CNT_W-1:0]       o_overrun_count,
    output logic [CNT_W-1:0]       o_underrun_count
);

    // configuration
    logic [THR_W-1:0] r_warmup;
    logic [LEN_W-1:0] r_chunk_len;

    // captured item
    logic                r_command;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_pkt_start;

    // state
    logic [PTR_W-1:0]  r_wr_ptr,  n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr,  n_rd_ptr;
    logic [FILL_W-1:0] r_fill,    n_fill;
    logic              r_started, n_started;
    logic [POS_W-1:0]  r_pos,     n_pos;
    logic [LEN_W-1:0]  r_take,    n_take;
    logic              r_dropped, n_dropped;
    logic [CNT_W-1:0]  r_overruns,  n_overruns;
    logic [CNT_W-1:0]  r_underruns, n_underruns;

    // result registers
    logic [OUT_W-1:0]   r_value;
    logic               r_from_buf;
    logic               r_playing;
    logic [LEVEL_W-1:0] r_level;

    logic [SAMPLE_W-1:0] rdata;
    logic                ram_we;
    logic [LEN_W-1:0]    eff_len;
    logic [LEN_W-1:0]    take_now;
    logic [LEN_W-1:0]    pos_inc;
    logic [THR_W-1:0]    fill_ext;
    logic                full;
    logic                deliver;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] res;
        res = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return res;
    endfunction

    assign ram_we = i_cmd.exec && (r_command == CMD_PUSH);

    ajrb_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (r_sample),
        .i_raddr (r_rd_ptr),
        .o_rdata (rdata)
    );

    // chunk length 0 acts as 1, above the maximum clamps
    always_comb begin
        if (r_chunk_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_chunk_len > LEN_W'(CHUNK_MAX)) begin
            eff_len = LEN_W'(CHUNK_MAX);
        end else begin
            eff_len = r_chunk_len;
        end
    end

    assign fill_ext = THR_W'(r_fill);
    assign full     = (r_fill == FILL_W'(RING_DEPTH));
    assign pos_inc  = LEN_W'(r_pos) + LEN_W'(1);

    always_comb begin
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_fill      = r_fill;
        n_started   = r_started;
        n_pos       = r_pos;
        n_take      = r_take;
        n_dropped   = r_dropped;
        n_overruns  = r_overruns;
        n_underruns = r_underruns;
        take_now    = r_take;
        deliver     = 1'b0;

        if (r_command == CMD_PUSH) begin
            if (r_pkt_start) n_dropped = 1'b0;
            // full: drop the oldest sample first, net fill unchanged
            if (full) begin
                n_rd_ptr = ptr_next(r_rd_ptr);
                if (r_take != '0) n_take = r_take - LEN_W'(1);
                if (!n_dropped) begin
                    n_overruns = r_overruns + CNT_W'(1);
                    n_dropped  = 1'b1;
                end
            end else begin
                n_fill = r_fill + FILL_W'(1);
            end
            n_wr_ptr = ptr_next(r_wr_ptr);
        end else begin
            if (!r_started && (fill_ext >= r_warmup)) n_started = 1'b1;
            if (n_started) begin
                if (r_pos == '0) begin
                    take_now = (THR_W'(eff_len) <= fill_ext) ? eff_len : LEN_W'(r_fill);
                    if (fill_ext < THR_W'(eff_len)) n_underruns = r_underruns + CNT_W'(1);
                end
                n_take = take_now;
                if ((take_now != '0) && (r_fill != '0)) begin
                    deliver  = 1'b1;
                    n_rd_ptr = ptr_next(r_rd_ptr);
                    n_fill   = r_fill - FILL_W'(1);
                    n_take   = take_now - LEN_W'(1);
                end
                n_pos = (pos_inc >= eff_len) ? '0 : POS_W'(pos_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warmup    <= WARMUP_RESET;
            r_chunk_len <= CHUNK_RESET;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_fill      <= '0;
            r_started   <= 1'b0;
            r_pos       <= '0;
            r_take      <= '0;
            r_dropped   <= 1'b0;
            r_overruns  <= '0;
            r_underruns <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_WARMUP: r_warmup    <= THR_W'(i_cfg_data);
                    REG_CHUNK:  r_chunk_len <= i_cfg_data[LEN_W-1:0];
                    default:    ;
                endcase
            end
            if (i_cmd.exec) begin
                r_wr_ptr    <= n_wr_ptr;
                r_rd_ptr    <= n_rd_ptr;
                r_fill      <= n_fill;
                r_started   <= n_started;
                r_pos       <= n_pos;
                r_take      <= n_take;
                r_dropped   <= n_dropped;
                r_overruns  <= n_overruns;
                r_underruns <= n_underruns;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_command   <= i_command;
            r_sample    <= i_sample;
            r_pkt_start <= i_packet_start;
        end
        if (i_cmd.exec) begin
            r_value    <= deliver ? {rdata, {(OUT_W-SAMPLE_W){1'b0}}} : '0;
            r_from_buf <= deliver;
            r_playing  <= n_started;
            r_level    <= LEVEL_W'(n_fill);
        end
    end

    assign o_left_sample    = r_value;
    assign o_right_sample   = r_value;
    assign o_from_buffer    = r_from_buf;
    assign o_playing        = r_playing;
    assign o_fill_level     = r_level;
    assign o_overrun_count  = r_overruns;
    assign o_underrun_count = r_underruns;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(RING_DEPTH))
        else $error("fill above ring depth");

    a_take_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_take <= LEN_W'(CHUNK_MAX))
        else $error("reserved count above chunk maximum");

    // a delivered pop needs a non-empty ring and drains it by one
    a_deliver_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && deliver) |=> (r_fill == $past(r_fill) - FILL_W'(1)))
        else $error("delivered pop did not drain one sample");

endmodule

[rtl/audio_jitter_ring_buffer.sv]
// ----------------------------------------------------------------------------
// audio_jitter_ring_buffer
// Mono 16-bit jitter buffer in a ring RAM, drop-oldest on overrun,
// warm-up gated stereo playback in chunks with underrun accounting.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                        | payload
//  ---------+----------------------------------+-------------------------------
//  command  | start & !busy                    | i_command, i_sample,
//           |                                  | i_packet_start
//  result   | o_done (one-cycle strobe)        | o_left_sample .. o_underrun_count
//  config   | i_cfg_valid & o_cfg_ready        | i_cfg_index, i_cfg_data
//
//  Each command has the transfer cycle, then the execute cycle
//  in which the RAM's registered read data (addressed by the read pointer
//  at the transfer edge) is used. o_done strobes in the cycle after execute,
//  and the next command can be transferred in that same cycle.
//  Reset (i_rst_n low, synchronous) clears pointers, fill, counters and
//  loads the register defaults; the sample RAM is not cleared.
//  The result side cannot stall: each result is valid for one cycle only.
//  Config writes are always taken (o_cfg_ready tied high); write only
//  while idle.
// ----------------------------------------------------------------------------
module audio_jitter_ring_buffer import ajrb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command transfer
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_command,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic                  i_packet_start,
    // result
    output logic                  o_done,
    output logic [OUT_W-1:0]      o_left_sample,
    output logic [OUT_W-1:0]      o_right_sample,
    output logic                  o_from_buffer,
    output logic                  o_playing,
    output logic [LEVEL_W-1:0]    o_fill_level,
    output logic [CNT_W-1:0]      o_overrun_count,
    output logic [CNT_W-1:0]      o_underrun_count,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd cmd;
    logic    cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // sequencer
    ajrb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    // ring, chunk and counter datapath
    ajrb_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_command        (i_command),
        .i_sample         (i_sample),
        .i_packet_start   (i_packet_start),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_left_sample    (o_left_sample),
        .o_right_sample   (o_right_sample),
        .o_from_buffer    (o_from_buffer),
        .o_playing        (o_playing),
        .o_fill_level     (o_fill_level),
        .o_overrun_count  (o_overrun_count),
        .o_underrun_count (o_underrun_count)
    );

endmodule

[bench/audio_jitter_ring_buffer_tb.sv]
// ----------------------------------------------------------------------------
// audio_jitter_ring_buffer_tb
// Self-checking bench for the jitter buffer: commands go in through the
// start/busy port and every result strobe is matched, field by field, with
// the oldest value worked out by an in-bench copy of the buffer's behavior.
// Covers silence before warm-up, the warm-up start, chunk length limits,
// mid-chunk length changes and random push/pop traffic under changing
// settings.
// ----------------------------------------------------------------------------
module audio_jitter_ring_buffer_tb;
    import ajrb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // one result as the block reports it
    typedef struct packed {
        logic [OUT_W-1:0]   left_smp;
        logic [OUT_W-1:0]   right_smp;
        logic               from_buf;
        logic               playing;
        logic [LEVEL_W-1:0] level;
        logic [CNT_W-1:0]   overruns;
        logic [CNT_W-1:0]   underruns;
    } t_play_result;

    localparam int RANDOM_ITEMS = 1580;
    localparam int MAX_REPORTS  = 50;

    logic                  i_clk;
    logic                  i_rst_n        = 1'b0;
    logic                  start          = 1'b0;
    logic                  busy;
    logic                  i_command      = CMD_PUSH;
    logic [SAMPLE_W-1:0]   i_sample       = '0;
    logic                  i_packet_start = 1'b0;
    logic                  o_done;
    logic [OUT_W-1:0]      o_left_sample;
    logic [OUT_W-1:0]      o_right_sample;
    logic                  o_from_buffer;
    logic                  o_playing;
    logic [LEVEL_W-1:0]    o_fill_level;
    logic [CNT_W-1:0]      o_overrun_count;
    logic [CNT_W-1:0]      o_underrun_count;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    audio_jitter_ring_buffer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_sample         (i_sample),
        .i_packet_start   (i_packet_start),
        .o_done           (o_done),
        .o_left_sample    (o_left_sample),
        .o_right_sample   (o_right_sample),
        .o_from_buffer    (o_from_buffer),
        .o_playing        (o_playing),
        .o_fill_level     (o_fill_level),
        .o_overrun_count  (o_overrun_count),
        .o_underrun_count (o_underrun_count),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Buffer state as the bench tracks it. Updated at the edge where a
    // command transfer happens, so it always reflects accepted commands.
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] ring_mem [0:RING_DEPTH-1];
    int unsigned         wr_ptr      = 0;
    int unsigned         rd_ptr      = 0;
    int unsigned         held        = 0;    // samples in the ring
    int unsigned         chunk_pos   = 0;
    int unsigned         reserved    = 0;    // samples still owed to this chunk
    bit                  started_q   = 1'b0;
    bit                  pkt_dropped = 1'b0; // current packet already counted
    logic [CNT_W-1:0]    ovr_cnt     = '0;
    logic [CNT_W-1:0]    udr_cnt     = '0;
    logic [THR_W-1:0]    warm_thr    = WARMUP_RESET;
    logic [LEN_W-1:0]    chunk_len   = CHUNK_RESET;

    t_play_result pending_results [$];
    int           mismatches = 0;

    // generous hang guard; the slowest legal run is far below this
    initial begin
        #5ms;
        $display("%0t: timeout, results still pending: %0d", $time, pending_results.size());
        $display("audio_jitter_ring_buffer_tb NOT OK");
        $finish;
    end

    // Apply one command to the tracked state and return what the block
    // should report for it.
    function automatic t_play_result predict_step(input logic cmd,
                                                  input logic [SAMPLE_W-1:0] smp,
                                                  input logic pkt);
        t_play_result r;
        int unsigned  len;
        r = '0;
        if (cmd == CMD_PUSH) begin
            if (pkt)
                pkt_dropped = 1'b0;
            // full ring: drop the oldest, which may be one this chunk reserved
            if (held >= RING_DEPTH) begin
                rd_ptr = (rd_ptr + 1) % RING_DEPTH;
                held--;
                if (reserved > 0)
                    reserved--;
                if (!pkt_dropped) begin
                    ovr_cnt++;
                    pkt_dropped = 1'b1;
                end
            end
            ring_mem[wr_ptr] = smp;
            wr_ptr = (wr_ptr + 1) % RING_DEPTH;
            held++;
        end else begin
            // warm-up is judged on the fill before this pop
            if (!started_q && held >= warm_thr)
                started_q = 1'b1;
            if (started_q) begin
                len = (chunk_len == 0)         ? 1 :
                      (chunk_len > CHUNK_MAX)  ? CHUNK_MAX : chunk_len;
                if (chunk_pos == 0) begin
                    reserved = (len < held) ? len : held;
                    if (reserved < len)
                        udr_cnt++;
                end
                if (reserved > 0 && held > 0) begin
                    r.left_smp  = {ring_mem[rd_ptr], 16'h0000};
                    r.right_smp = r.left_smp;
                    r.from_buf  = 1'b1;
                    rd_ptr = (rd_ptr + 1) % RING_DEPTH;
                    held--;
                    reserved--;
                end
                chunk_pos++;
                if (chunk_pos >= len)
                    chunk_pos = 0;
            end
        end
        r.playing   = started_q;
        r.level     = LEVEL_W'(held);
        r.overruns  = ovr_cnt;
        r.underruns = udr_cnt;
        return r;
    endfunction

    // No gap unless the idle_pct draw hits; then usually a short one, rarely a long one.
    function automatic int pick_gap(input int idle_pct);
        if ($urandom_range(99) >= idle_pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(40, 10);
        return $urandom_range(3, 1);
    endfunction

    // ------------------------------------------------------------------
    // Command side. Inputs move at the falling edge; the transfer is seen
    // at the rising edge where start is high and busy low. start stays up
    // back to back and is only lowered for a gap or an idle wait.
    // ------------------------------------------------------------------
    task automatic issue_cmd(input logic cmd, input logic [SAMPLE_W-1:0] smp,
                             input logic pkt, input int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start          <= 1'b1;
        i_command      <= cmd;
        i_sample       <= smp;
        i_packet_start <= pkt;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(predict_step(cmd, smp, pkt));
    endtask

    task automatic push_packet(input int n, input int idle_pct);
        int i;
        for (i = 0; i < n; i++)
            issue_cmd(CMD_PUSH, SAMPLE_W'($urandom), (i == 0), pick_gap(idle_pct));
    endtask

    // pop carries junk in the ignored fields on purpose
    task automatic pop_n(input int n, input int idle_pct);
        int i;
        for (i = 0; i < n; i++)
            issue_cmd(CMD_POP, SAMPLE_W'($urandom), 1'($urandom), pick_gap(idle_pct));
    endtask

    // Stop sending and wait until every result has been strobed out.
    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
    endtask

    // Register write, only ever done with the command side drained.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_WARMUP: warm_thr  = data[THR_W-1:0];
            REG_CHUNK:  chunk_len = data[LEN_W-1:0];
            default: ;  // unknown index, no effect
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: the block cannot be held off, so every strobe is
    // checked at the edge that ends it.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            if (mismatches < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_play_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: result strobe with nothing pending", $time);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("left_sample",    want.left_smp,  o_left_sample);
                check_field("right_sample",   want.right_smp, o_right_sample);
                check_field("from_buffer",    32'(want.from_buf), 32'(o_from_buffer));
                check_field("playing",        32'(want.playing),  32'(o_playing));
                check_field("fill_level",     32'(want.level),    32'(o_fill_level));
                check_field("overrun_count",  want.overruns,  o_overrun_count);
                check_field("underrun_count", want.underruns, o_underrun_count);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Default settings, almost empty ring: every pop must be silence.
    // Writes to the unused register slots must change nothing.
    task automatic test_cold_silence();
        pop_n(1, 0);
        issue_cmd(CMD_PUSH, 16'h8000, 1'b1, 0);
        issue_cmd(CMD_PUSH, 16'h7FFF, 1'b0, 0);
        issue_cmd(CMD_PUSH, 16'h0000, 1'b0, 1);
        issue_cmd(CMD_PUSH, 16'hFFFF, 1'b1, 0);
        issue_cmd(CMD_PUSH, 16'h0001, 1'b0, 0);
        pop_n(2, 0);
        cfg_write(CFG_IDX_W'(2), {CFG_DATA_W{1'b1}});
        cfg_write(CFG_IDX_W'(3), '0);
        pop_n(1, 0);
        wait_drained();
    endtask

    // Low threshold: pops stay silent until the fill reaches it, then the
    // first chunk reserves what is there, runs short, plays the reserved samples and then silence.
    task automatic test_warmup_start();
        cfg_write(REG_WARMUP, CFG_DATA_W'(12));
        push_packet(4, 0);
        pop_n(2, 10);
        push_packet(3, 10);
        pop_n(14, 10);
        wait_drained();
    endtask

    // Chunk length limits with an almost empty ring, sample extremes
    // played back, and a length change in the middle of a long chunk.
    task automatic test_chunk_boundaries();
        logic [SAMPLE_W-1:0] corner_vals [5];
        int i;
        corner_vals = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h0001};
        cfg_write(REG_CHUNK, CFG_DATA_W'(1));
        pop_n(2, 0);
        for (i = 0; i < 5; i++)
            issue_cmd(CMD_PUSH, corner_vals[i], (i == 0), 0);
        pop_n(6, 0);
        // only the low 11 bits count: this is a length of zero
        cfg_write(REG_CHUNK, 17'h1F800);
        push_packet(1, 0);
        pop_n(2, 0);
        cfg_write(REG_CHUNK, CFG_DATA_W'(CHUNK_MAX));
        push_packet(4, 0);
        pop_n(6, 0);
        cfg_write(REG_CHUNK, CFG_DATA_W'(3));
        pop_n(1, 0);
        push_packet(5, 0);
        pop_n(4, 0);
        cfg_write(REG_CHUNK, CFG_DATA_W'(2047));
        push_packet(2, 0);
        pop_n(3, 0);
        cfg_write(REG_WARMUP, '0);
        pop_n(1, 0);
        wait_drained();
    endtask

    // Random push/pop mix in segments, each with its own settings, push
    // bias and idle rate, so the fill wanders between empty and a few
    // hundred and chunks both complete and run short.
    task automatic test_random_traffic();
        int                    sent;
        int                    k;
        int                    seg_len;
        int                    push_pct;
        int                    idle_pct;
        int unsigned           len;
        logic [CFG_DATA_W-1:0] data;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(5))
                0:       len = 0;
                1:       len = CHUNK_MAX;
                2:       len = $urandom_range(2047, CHUNK_MAX + 1);
                3:       len = $urandom_range(2047);
                default: len = $urandom_range(16, 1);
            endcase
            data = CFG_DATA_W'($urandom);
            data[LEN_W-1:0] = LEN_W'(len);
            cfg_write(REG_CHUNK, data);
            if ($urandom_range(2) == 0)
                cfg_write(REG_WARMUP, CFG_DATA_W'($urandom));
            if ($urandom_range(5) == 0)
                cfg_write(CFG_IDX_W'($urandom_range(3, 2)), CFG_DATA_W'($urandom));

            seg_len  = $urandom_range(200, 50);
            push_pct = $urandom_range(75, 25);
            case ($urandom_range(2))
                0:       idle_pct = 0;
                1:       idle_pct = 15;
                default: idle_pct = 50;
            endcase
            for (k = 0; k < seg_len; k++) begin
                if ($urandom_range(99) < push_pct)
                    issue_cmd(CMD_PUSH, SAMPLE_W'($urandom), ($urandom_range(99) < 30),
                              pick_gap(idle_pct));
                else
                    pop_n(1, idle_pct);
                // let the block run dry now and then
                if ($urandom_range(199) == 0)
                    wait_drained();
            end
            sent += seg_len;
        end
        wait_drained();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_cold_silence();
        test_warmup_start();
        test_chunk_boundaries();
        test_random_traffic();

        wait_drained();
        // catch any stray strobe after the last result
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("audio_jitter_ring_buffer_tb OK");
        else
            $display("audio_jitter_ring_buffer_tb NOT OK");
        $finish;
    end

endmodule
